>>> rtl/core/pdw_pkg.sv
// pdw_pkg: shared types and constants for pixel_depth_to_world_point.
// Item structs, sequencer states, register indexes, product slots.
// No dependencies.
package pdw_pkg;

  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulBW  = 27;
  localparam int unsigned MulPW  = MulAW + MulBW;
  localparam int unsigned DivNW  = 48;
  localparam int unsigned DivDW  = 16;
  localparam int unsigned DivCntW = $clog2(DivNW);

  typedef struct packed {
    logic        [15:0] pixel_u;
    logic        [15:0] pixel_v;
    logic        [30:0] depth;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               found;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic               found_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAM_MUL,
    ST_CAM_USE,
    ST_DIV,
    ST_QMUL,
    ST_QUSE,
    ST_RSEL,
    ST_RMUL,
    ST_RACC,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CFG_FOCAL_X  = 2'd0,
    CFG_FOCAL_Y  = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_idx_e;

  // quaternion product slots
  localparam logic [3:0] QP_XX = 4'd0;
  localparam logic [3:0] QP_YY = 4'd1;
  localparam logic [3:0] QP_ZZ = 4'd2;
  localparam logic [3:0] QP_XY = 4'd3;
  localparam logic [3:0] QP_XZ = 4'd4;
  localparam logic [3:0] QP_YZ = 4'd5;
  localparam logic [3:0] QP_WX = 4'd6;
  localparam logic [3:0] QP_WY = 4'd7;
  localparam logic [3:0] QP_WZ = 4'd8;
  localparam int unsigned QpNum = 9;

  localparam logic [3:0] CAM_LAST = 4'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/pdw_if.sv
// pdw_in_if / pdw_out_if: valid/ready channels for input and result items.
// Depends on pdw_pkg item types.
interface pdw_in_if;
  logic              valid;
  logic              ready;
  pdw_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdw_out_if;
  logic               valid;
  logic               ready;
  pdw_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/pixel_depth_to_world_point.sv
// pixel_depth_to_world_point: pixel + depth back-projection and pose transform.
// Sequencer around pdw_mul and pdw_div; uses pdw_pkg and pdw_if.
//
//   channel   dir   handshake        payload
//   in_i      in    valid/ready      pdw_pkg::in_item_t
//   out_o     out   valid/ready      pdw_pkg::out_item_t
//   cfg       in    cfg_we_i         cfg_idx_i, cfg_data_i
//
// Each item passes, accept to next accept, through two divides (multiply,
// divider start, a 48-bit quotient, done), 9 quaternion products, 9 rotation
// terms, 3 row write-backs, done and idle. Ready only in idle; a result
// waits in the output register while the next item runs, and a second one
// holds the sequencer in done until the first leaves. Reset clears held
// values and restores config.
module pixel_depth_to_world_point (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  pdw_in_if.sink      in_i,
  pdw_out_if.source   out_o
);

  localparam logic signed [34:0] ROne = 35'sd268435456;

  pdw_pkg::state_e st_q, st_d;

  logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [15:0] held_u_q, held_v_q;
  logic [30:0] held_d_q;
  logic [3:0]  k_q;
  logic [1:0]  row_q, col_q;
  logic        ov_q;

  logic signed [31:0] pos_q [3];
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
  logic               found_q;
  logic signed [31:0] qp_q [pdw_pkg::QpNum];
  logic signed [31:0] cam_x_q, cam_y_q;
  logic               neg_q;
  logic signed [26:0] rr_q;
  logic signed [61:0] acc_q;
  logic signed [31:0] world_q [3];
  pdw_pkg::out_item_t out_q;

  logic                               in_acc;
  logic                               mul_en;
  logic                               div_start;
  logic signed [pdw_pkg::MulAW-1:0]   mul_a;
  logic signed [pdw_pkg::MulBW-1:0]   mul_b;
  logic signed [pdw_pkg::MulPW-1:0]   prod;
  logic [pdw_pkg::DivNW-1:0]          dividend;
  logic [pdw_pkg::DivNW-1:0]          quo;
  logic [15:0]                        focal_eff;
  pdw_pkg::div_stat_t                 div_stat;
  logic signed [16:0]                 diff;
  logic signed [32:0]                 body;
  logic signed [34:0]                 r_raw;
  logic [pdw_pkg::MulPW-1:0]          mag;
  logic [31:0]                        cam_res;
  logic signed [31:0]                 pos_sel;
  logic signed [31:0]                 world_res;
  logic                               out_load;

  function automatic logic signed [26:0] rnd8(input logic signed [34:0] v);
    logic [34:0] m;
    logic [26:0] s;
    m = v[34] ? $unsigned(-v) : $unsigned(v);
    m = m + 35'd128;
    s = m[34:8];
    return v[34] ? $signed(-s) : $signed(s);
  endfunction

  function automatic logic signed [41:0] rnd20(input logic signed [61:0] v);
    logic [61:0] m;
    logic [41:0] s;
    m = v[61] ? $unsigned(-v) : $unsigned(v);
    m = m + 62'd524288;
    s = m[61:20];
    return v[61] ? $signed(-s) : $signed(s);
  endfunction

  function automatic logic signed [31:0] sat_world(input logic signed [41:0] r,
                                                   input logic signed [31:0] p);
    logic signed [42:0] sum;
    sum = 43'(r) + 43'(p);
    if (sum > 43'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (sum < -43'sd2147483648) begin
      return 32'sh80000000;
    end
    return sum[31:0];
  endfunction

  assign in_acc = in_i.valid && in_i.ready;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      pdw_pkg::ST_IDLE:    if (in_i.valid) st_d = pdw_pkg::ST_CAM_MUL;
      pdw_pkg::ST_CAM_MUL: st_d = pdw_pkg::ST_CAM_USE;
      pdw_pkg::ST_CAM_USE: st_d = pdw_pkg::ST_DIV;
      pdw_pkg::ST_DIV: begin
        if (div_stat.done) begin
          st_d = (k_q == pdw_pkg::CAM_LAST) ? pdw_pkg::ST_QMUL : pdw_pkg::ST_CAM_MUL;
        end
      end
      pdw_pkg::ST_QMUL:    st_d = pdw_pkg::ST_QUSE;
      pdw_pkg::ST_QUSE:    st_d = (k_q == pdw_pkg::QP_WZ) ? pdw_pkg::ST_RSEL : pdw_pkg::ST_QMUL;
      pdw_pkg::ST_RSEL:    st_d = pdw_pkg::ST_RMUL;
      pdw_pkg::ST_RMUL:    st_d = pdw_pkg::ST_RACC;
      pdw_pkg::ST_RACC:    st_d = (col_q == 2'd2) ? pdw_pkg::ST_WRITE : pdw_pkg::ST_RSEL;
      pdw_pkg::ST_WRITE:   st_d = (row_q == 2'd2) ? pdw_pkg::ST_DONE : pdw_pkg::ST_RSEL;
      pdw_pkg::ST_DONE:    if (!ov_q || out_o.ready) st_d = pdw_pkg::ST_IDLE;
      default:             st_d = pdw_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready = (st_q == pdw_pkg::ST_IDLE);
    mul_en     = (st_q == pdw_pkg::ST_CAM_MUL) || (st_q == pdw_pkg::ST_QMUL) ||
                 (st_q == pdw_pkg::ST_RMUL);
    div_start  = (st_q == pdw_pkg::ST_CAM_USE);
    out_load   = (st_q == pdw_pkg::ST_DONE) && (!ov_q || out_o.ready);
  end

  assign diff = k_q[0] ? ($signed({1'b0, held_v_q}) - $signed({1'b0, center_y_q}))
                       : ($signed({1'b0, held_u_q}) - $signed({1'b0, center_x_q}));

  always_comb begin
    unique case (col_q)
      2'd0:    body = $signed({2'b00, held_d_q});
      2'd1:    body = -(33'(cam_x_q));
      2'd2:    body = -(33'(cam_y_q));
      default: body = '0;
    endcase
  end

  always_comb begin
    mul_a = body;
    mul_b = rr_q;
    unique case (st_q)
      pdw_pkg::ST_CAM_MUL: begin
        mul_a = $signed({2'b00, held_d_q});
        mul_b = 27'(diff);
      end
      pdw_pkg::ST_QMUL: begin
        unique case (k_q)
          pdw_pkg::QP_XX: begin mul_a = 33'(qx_q); mul_b = 27'(qx_q); end
          pdw_pkg::QP_YY: begin mul_a = 33'(qy_q); mul_b = 27'(qy_q); end
          pdw_pkg::QP_ZZ: begin mul_a = 33'(qz_q); mul_b = 27'(qz_q); end
          pdw_pkg::QP_XY: begin mul_a = 33'(qx_q); mul_b = 27'(qy_q); end
          pdw_pkg::QP_XZ: begin mul_a = 33'(qx_q); mul_b = 27'(qz_q); end
          pdw_pkg::QP_YZ: begin mul_a = 33'(qy_q); mul_b = 27'(qz_q); end
          pdw_pkg::QP_WX: begin mul_a = 33'(qw_q); mul_b = 27'(qx_q); end
          pdw_pkg::QP_WY: begin mul_a = 33'(qw_q); mul_b = 27'(qy_q); end
          pdw_pkg::QP_WZ: begin mul_a = 33'(qw_q); mul_b = 27'(qz_q); end
          default:        begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: ;
    endcase
  end

  pdw_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // rounded quotient: (|num| + focal/2) / focal
  assign focal_eff = k_q[0] ? ((focal_y_q == '0) ? 16'd1 : focal_y_q)
                            : ((focal_x_q == '0) ? 16'd1 : focal_x_q);
  assign mag       = prod[pdw_pkg::MulPW-1] ? $unsigned(-prod) : $unsigned(prod);
  assign dividend  = mag[pdw_pkg::DivNW-1:0] + {33'd0, focal_eff[15:1]};

  pdw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (focal_eff),
    .quo_o      (quo),
    .stat_o     (div_stat)
  );

  always_comb begin
    if (!neg_q) begin
      cam_res = (quo > 48'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
    end else begin
      cam_res = (quo > 48'h80000000) ? 32'h80000000 : (32'd0 - quo[31:0]);
    end
  end

  always_comb begin
    unique case ({row_q, col_q})
      4'b0000: r_raw = ROne - ((35'(qp_q[pdw_pkg::QP_YY]) + 35'(qp_q[pdw_pkg::QP_ZZ])) <<< 1);
      4'b0001: r_raw = (35'(qp_q[pdw_pkg::QP_XY]) - 35'(qp_q[pdw_pkg::QP_WZ])) <<< 1;
      4'b0010: r_raw = (35'(qp_q[pdw_pkg::QP_XZ]) + 35'(qp_q[pdw_pkg::QP_WY])) <<< 1;
      4'b0100: r_raw = (35'(qp_q[pdw_pkg::QP_XY]) + 35'(qp_q[pdw_pkg::QP_WZ])) <<< 1;
      4'b0101: r_raw = ROne - ((35'(qp_q[pdw_pkg::QP_XX]) + 35'(qp_q[pdw_pkg::QP_ZZ])) <<< 1);
      4'b0110: r_raw = (35'(qp_q[pdw_pkg::QP_YZ]) - 35'(qp_q[pdw_pkg::QP_WX])) <<< 1;
      4'b1000: r_raw = (35'(qp_q[pdw_pkg::QP_XZ]) - 35'(qp_q[pdw_pkg::QP_WY])) <<< 1;
      4'b1001: r_raw = (35'(qp_q[pdw_pkg::QP_YZ]) + 35'(qp_q[pdw_pkg::QP_WX])) <<< 1;
      4'b1010: r_raw = ROne - ((35'(qp_q[pdw_pkg::QP_XX]) + 35'(qp_q[pdw_pkg::QP_YY])) <<< 1);
      default: r_raw = '0;
    endcase
  end

  always_comb begin
    unique case (row_q)
      2'd0:    pos_sel = pos_q[0];
      2'd1:    pos_sel = pos_q[1];
      2'd2:    pos_sel = pos_q[2];
      default: pos_sel = '0;
    endcase
  end

  assign world_res = sat_world(rnd20(acc_q), pos_sel);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= pdw_pkg::ST_IDLE;
      focal_x_q  <= 16'd9600;
      focal_y_q  <= 16'd9600;
      center_x_q <= 16'd5120;
      center_y_q <= 16'd3840;
      held_u_q   <= '0;
      held_v_q   <= '0;
      held_d_q   <= '0;
      k_q        <= '0;
      row_q      <= '0;
      col_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (pdw_pkg::cfg_idx_e'(cfg_idx_i))
          pdw_pkg::CFG_FOCAL_X:  focal_x_q  <= cfg_data_i;
          pdw_pkg::CFG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
          pdw_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i;
          pdw_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_i.data.pixel_u != '0) held_u_q <= in_i.data.pixel_u;
        if (in_i.data.pixel_v != '0) held_v_q <= in_i.data.pixel_v;
        if (in_i.data.depth != '0)   held_d_q <= in_i.data.depth;
        k_q <= '0;
      end
      if (st_q == pdw_pkg::ST_DIV && div_stat.done) begin
        k_q <= (k_q == pdw_pkg::CAM_LAST) ? 4'd0 : k_q + 4'd1;
      end
      if (st_q == pdw_pkg::ST_QUSE) begin
        k_q   <= k_q + 4'd1;
        row_q <= '0;
        col_q <= '0;
      end
      if (st_q == pdw_pkg::ST_RACC && col_q != 2'd2) begin
        col_q <= col_q + 2'd1;
      end
      if (st_q == pdw_pkg::ST_WRITE) begin
        row_q <= row_q + 2'd1;
        col_q <= '0;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q[0] <= in_i.data.pos_x;
      pos_q[1] <= in_i.data.pos_y;
      pos_q[2] <= in_i.data.pos_z;
      qw_q     <= in_i.data.quat_w;
      qx_q     <= in_i.data.quat_x;
      qy_q     <= in_i.data.quat_y;
      qz_q     <= in_i.data.quat_z;
      found_q  <= in_i.data.found;
    end
    if (st_q == pdw_pkg::ST_CAM_USE) begin
      neg_q <= prod[pdw_pkg::MulPW-1];
    end
    if (st_q == pdw_pkg::ST_DIV && div_stat.done) begin
      if (k_q[0]) cam_y_q <= $signed(cam_res);
      else        cam_x_q <= $signed(cam_res);
    end
    if (st_q == pdw_pkg::ST_QUSE) begin
      qp_q[k_q] <= prod[31:0];
      acc_q     <= '0;
    end
    if (st_q == pdw_pkg::ST_RSEL) begin
      rr_q <= rnd8(r_raw);
    end
    if (st_q == pdw_pkg::ST_RACC) begin
      acc_q <= acc_q + 62'(prod);
    end
    if (st_q == pdw_pkg::ST_WRITE) begin
      world_q[row_q] <= world_res;
      acc_q          <= '0;
    end
    if (out_load) begin
      out_q.world_x   <= world_q[0];
      out_q.world_y   <= world_q[1];
      out_q.world_z   <= world_q[2];
      out_q.found_out <= found_q;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(st_q == pdw_pkg::ST_DONE))
    else $error("result valid without finished item");

  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (st_q == pdw_pkg::ST_DIV))
    else $error("divider busy outside divide step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q == pdw_pkg::ST_CAM_MUL))
    else $error("accepted item did not start");
`endif

endmodule

>>> rtl/core/pdw_mul.sv
// pdw_mul: shared signed multiplier with registered product.
// Depends on pdw_pkg widths.
module pdw_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [pdw_pkg::MulAW-1:0]    a_i,
  input  logic signed [pdw_pkg::MulBW-1:0]    b_i,
  output logic signed [pdw_pkg::MulPW-1:0]    p_o
);

  logic signed [pdw_pkg::MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= pdw_pkg::MulPW'(a_i) * pdw_pkg::MulPW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/pdw_div.sv
// pdw_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on pdw_pkg widths and status struct.
module pdw_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pdw_pkg::DivNW-1:0]     dividend_i,
  input  logic [pdw_pkg::DivDW-1:0]     divisor_i,
  output logic [pdw_pkg::DivNW-1:0]     quo_o,
  output pdw_pkg::div_stat_t            stat_o
);

  logic [pdw_pkg::DivNW-1:0]   quo_q;
  logic [pdw_pkg::DivDW-1:0]   rem_q;
  logic [pdw_pkg::DivDW-1:0]   dsr_q;
  logic [pdw_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [pdw_pkg::DivDW:0]     shl;
  logic [pdw_pkg::DivDW:0]     trial;

  assign shl   = {rem_q, quo_q[pdw_pkg::DivNW-1]};
  assign trial = shl - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pdw_pkg::DivCntW'(pdw_pkg::DivNW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= trial[pdw_pkg::DivDW] ? shl[pdw_pkg::DivDW-1:0] : trial[pdw_pkg::DivDW-1:0];
      quo_q <= {quo_q[pdw_pkg::DivNW-2:0], ~trial[pdw_pkg::DivDW]};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> verif/tb_pixel_depth_to_world_point.sv
// Testbench for pixel_depth_to_world_point: drives detections and pose items,
// predicts world points with a fixed-point back-projection model and checks results.
// Depends on pdw_pkg, pdw_if and the block RTL.
`timescale 1ns / 100ps
module tb_pixel_depth_to_world_point;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  pdw_in_if in_ch ();
  pdw_out_if out_ch ();

  pixel_depth_to_world_point u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch), .out_o(out_ch)
  );

  always #6 clk_i = ~clk_i;

  logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [15:0] last_u, last_v;
  logic [30:0] last_depth;
  pdw_pkg::out_item_t world_pts[$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_ack = 0;
  bit rx_noidle = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint unsigned_div_round(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint sat_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic longint cam_coord(logic [15:0] pix, logic [15:0] ctr,
                                       logic [15:0] foc, logic [30:0] d);
    longint num, den;
    num = longint'(d) * (longint'(pix) - longint'(ctr));
    den = foc == 0 ? 1 : longint'(foc);
    return sat_q16(unsigned_div_round(num, den));
  endfunction

  function automatic pdw_pkg::out_item_t predict_world_point(pdw_pkg::in_item_t it);
    pdw_pkg::out_item_t r;
    longint body[3], rot[3][3], pos[3], acc, w, x, y, z, one;
    if (it.pixel_u != 0) last_u = it.pixel_u;
    if (it.pixel_v != 0) last_v = it.pixel_v;
    if (it.depth != 0) last_depth = it.depth;
    body[0] = longint'(last_depth);
    body[1] = -cam_coord(last_u, center_x_q, focal_x_q, last_depth);
    body[2] = -cam_coord(last_v, center_y_q, focal_y_q, last_depth);
    pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
    w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
    one = 64'sd1 <<< 28;
    rot[0][0] = one - 2 * (y * y + z * z);
    rot[0][1] = 2 * (x * y - w * z);
    rot[0][2] = 2 * (x * z + w * y);
    rot[1][0] = 2 * (x * y + w * z);
    rot[1][1] = one - 2 * (x * x + z * z);
    rot[1][2] = 2 * (y * z - w * x);
    rot[2][0] = 2 * (x * z - w * y);
    rot[2][1] = 2 * (y * z + w * x);
    rot[2][2] = one - 2 * (x * x + y * y);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rnd_shift(rot[i][j], 8) * body[j];
      acc = sat_q16(rnd_shift(acc, 20) + pos[i]);
      if (i == 0) r.world_x = acc[31:0];
      else if (i == 1) r.world_y = acc[31:0];
      else r.world_z = acc[31:0];
    end
    r.found_out = it.found;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  // valid drops only when a gap follows
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_item(pdw_pkg::in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    world_pts.push_back(predict_world_point(it));
    idle_gap();
  endtask

  task automatic write_reg(pdw_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      pdw_pkg::CFG_FOCAL_X: focal_x_q = val;
      pdw_pkg::CFG_FOCAL_Y: focal_y_q = val;
      pdw_pkg::CFG_CENTER_X: center_x_q = val;
      default: center_y_q = val;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (world_pts.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom());
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic pdw_pkg::in_item_t rand_item();
    pdw_pkg::in_item_t it;
    it.pixel_u = $urandom_range(0, 5) == 0 ? 16'd0 : 16'($urandom());
    it.pixel_v = $urandom_range(0, 5) == 0 ? 16'd0 : 16'($urandom());
    case ($urandom_range(0, 5))
      0: it.depth = '0;
      1: it.depth = 31'($urandom());
      default: it.depth = 31'($urandom_range(0, 32'h00FF_FFFF));
    endcase
    it.pos_x = $urandom_range(0, 1) ? $urandom() : $signed(32'($urandom_range(0, 32'h1FFFFF)))
               - 32'sh100000;
    it.pos_y = $urandom();
    it.pos_z = $urandom_range(0, 2) ? $signed(32'($urandom_range(0, 32'hFFFFF))) : $urandom();
    it.quat_w = rand_quat();
    it.quat_x = rand_quat();
    it.quat_y = rand_quat();
    it.quat_z = rand_quat();
    it.found = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic test_reset_defaults();
    pdw_pkg::in_item_t it;
    it = '0;
    send_item(it);
    it.pixel_u = 16'hFFFF; it.pixel_v = 16'hFFFF; it.depth = 31'h7FFFFFFF;
    it.pos_x = 32'sh7FFFFFFF; it.pos_y = 32'sh80000000; it.pos_z = 32'sh7FFFFFFF;
    it.quat_w = 16'sd16384; it.found = 1'b1;
    send_item(it);
    it = '0;
    it.quat_w = -16'sd16384; it.quat_x = 16'sd16384; it.quat_y = -16'sd16384;
    it.quat_z = 16'sd16384;
    send_item(it);
    it.pixel_u = 16'd1; it.pixel_v = 16'd1; it.depth = 31'd1;
    it.quat_w = 16'sh7FFF; it.quat_x = 16'sh8000; it.quat_y = 16'sh7FFF;
    it.quat_z = 16'sh8000;
    send_item(it);
    it.pixel_u = 16'd5120; it.pixel_v = 16'd3840; it.depth = 31'd65536;
    it.quat_w = 16'sd11585; it.quat_x = 0; it.quat_y = 0; it.quat_z = 16'sd11585;
    it.pos_x = -32'sd65536; it.pos_y = 0; it.pos_z = 0;
    send_item(it);
    drain();
  endtask

  task automatic test_extreme_config();
    pdw_pkg::in_item_t it;
    write_reg(pdw_pkg::CFG_FOCAL_X, 16'd0);
    write_reg(pdw_pkg::CFG_FOCAL_Y, 16'd1);
    write_reg(pdw_pkg::CFG_CENTER_X, 16'd0);
    write_reg(pdw_pkg::CFG_CENTER_Y, 16'hFFFF);
    for (int k = 0; k < 6; k++) begin
      it = rand_item();
      if (k < 2) it.depth = 31'h7FFFFFFF;
      if (k == 1) begin it.pixel_u = 0; it.pixel_v = 0; end
      send_item(it);
    end
    drain();
    write_reg(pdw_pkg::CFG_FOCAL_X, 16'hFFFF);
    write_reg(pdw_pkg::CFG_FOCAL_Y, 16'hFFFF);
    write_reg(pdw_pkg::CFG_CENTER_X, 16'hFFFF);
    write_reg(pdw_pkg::CFG_CENTER_Y, 16'd0);
    for (int k = 0; k < 6; k++) send_item(rand_item());
    drain();
  endtask

  task automatic test_backpressure();
    hold_req++;
    for (int k = 0; k < 5; k++) send_item(rand_item());
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(pdw_pkg::CFG_FOCAL_X, $urandom_range(0, 2) ? 16'($urandom_range(1000, 20000))
                : 16'($urandom()));
      write_reg(pdw_pkg::CFG_FOCAL_Y, $urandom_range(0, 2) ? 16'($urandom_range(1000, 20000))
                : 16'($urandom()));
      write_reg(pdw_pkg::CFG_CENTER_X, 16'($urandom()));
      write_reg(pdw_pkg::CFG_CENTER_Y, 16'($urandom()));
      rx_noidle = (ph == 2);
      for (int k = 0; k < 145; k++) send_item(rand_item());
      drain();
    end
    rx_noidle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= 600;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_noidle) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= $urandom_range(0, 15) == 0 ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    pdw_pkg::out_item_t exp;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (world_pts.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        exp = world_pts.pop_front();
        if (out_ch.data.world_x !== exp.world_x)
          report_mismatch("world_x", out_ch.data.world_x, exp.world_x);
        if (out_ch.data.world_y !== exp.world_y)
          report_mismatch("world_y", out_ch.data.world_y, exp.world_y);
        if (out_ch.data.world_z !== exp.world_z)
          report_mismatch("world_z", out_ch.data.world_z, exp.world_z);
        if (out_ch.data.found_out !== exp.found_out)
          report_mismatch("found_out", out_ch.data.found_out, exp.found_out);
      end
    end
  end

  initial begin
    focal_x_q = 16'd9600; focal_y_q = 16'd9600;
    center_x_q = 16'd5120; center_y_q = 16'd3840;
    last_u = '0; last_v = '0; last_depth = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extreme_config();
    test_backpressure();
    test_random();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/pdw_pkg.sv
rtl/core/pdw_if.sv
rtl/core/pdw_mul.sv
rtl/core/pdw_div.sv
rtl/core/pixel_depth_to_world_point.sv
verif/tb_pixel_depth_to_world_point.sv
